[rtl/rdm_pkg.sv]
`default_nettype none
package rdm_pkg;

	localparam int UidW = 48;
	localparam int TimeoutW = 14;
	localparam int CfgAddrW = 1;
	localparam int CfgDataW = 48;
	localparam logic [UidW-1:0] SourceUidReset = 48'hBBBB00000001;
	localparam logic [TimeoutW-1:0] TimeoutReset = 14'd2000;
	localparam logic [7:0] MaxParams = 8'd231;
	localparam logic [7:0] SumSeed = 8'hCC;
	localparam logic [7:0] StartCode = 8'h01;
	localparam logic [7:0] MinLength = 8'd24;
	localparam logic [7:0] GetResponse = 8'h21;
	localparam logic [7:0] SetResponse = 8'h31;
	localparam logic [7:0] RespAck = 8'h00;
	localparam logic [7:0] RespNack = 8'h02;
	localparam int QueueDepth = 4;
	localparam int HeaderBytes = 24;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_PARAM = 2'd1,
		CMD_RX    = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_TX      = 3'd0,
		KIND_ACK     = 3'd1,
		KIND_ACKDATA = 3'd2,
		KIND_NACK    = 3'd3,
		KIND_TIMEOUT = 3'd4
	} kind_t;

	localparam logic [CfgAddrW-1:0] REG_SOURCE_UID = 1'd0;
	localparam logic [CfgAddrW-1:0] REG_TIMEOUT = 1'd1;

	typedef struct packed {
		logic [1:0]  command;
		logic [47:0] dest_uid;
		logic [7:0]  command_class;
		logic [15:0] param_id;
		logic [7:0]  param_length;
		logic [7:0]  data_byte;
		logic        frame_first;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  out_byte;
		logic [47:0] device_uid;
		logic [15:0] report_pid;
		logic [7:0]  data_count;
		logic [15:0] nack_reason;
		logic        has_reason;
		logic        last;
	} out_word_t;

	// one classified job for the back part
	typedef struct packed {
		logic        timeout;     // report timeout first
		logic        header;      // emit request header
		logic        tx_one;      // emit one byte and add to sum
		logic        sum;         // emit checksum
		logic        report;      // emit one prepared report word
		logic [7:0]  tn;
		logic [47:0] dest;
		logic [47:0] src;
		logic [7:0]  cc;
		logic [15:0] pid;
		logic [7:0]  pdl;
		logic [7:0]  b;
		out_word_t   rep;
		logic [47:0] to_uid;
		logic [15:0] to_pid;
	} job_t;

endpackage
`default_nettype wire

[rtl/rdm_stream_if.sv]
`default_nettype none
interface rdm_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/rdm_front.sv]
`default_nettype none
module rdm_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [rdm_pkg::CfgAddrW-1:0] cfg_index,
	input  wire logic [rdm_pkg::CfgDataW-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire rdm_pkg::in_word_t in_data,
	output logic                   job_valid,
	input  wire logic              job_ready,
	output rdm_pkg::job_t          job
);
	import rdm_pkg::*;

	logic [47:0] src_q;
	logic [13:0] tmo_q;
	logic [7:0]  next_tn_q, pend_tn_q, params_left_q;
	logic        pend_q;
	logic [47:0] pend_uid_q;
	logic [15:0] pend_pid_q;
	logic [13:0] elapsed_q;
	logic [7:0]  rx_idx_q, rx_tn_q, rx_type_q, rx_len_q, rx_rh_q;
	logic        rx_rej_q;
	logic [47:0] rx_uid_q;
	logic [15:0] rx_pid_q;

	logic        acc;
	logic [7:0]  b, p, pdl, cnt, dn;
	logic [13:0] el_n;
	logic        first;
	job_t        j;

	assign in_ready = job_ready;
	assign acc = in_valid && job_ready;
	assign b = in_data.data_byte;
	assign first = in_data.frame_first;
	assign pdl = (in_data.param_length > MaxParams) ? MaxParams : in_data.param_length;
	assign p = first ? 8'd0 : rx_idx_q;
	assign cnt = (b > MaxParams) ? MaxParams : b;
	assign el_n = (elapsed_q != 14'h3FFF) ? elapsed_q + 14'd1 : elapsed_q;
	assign dn = p - 8'd23;

	always_comb begin
		j = '0;
		j.tn = next_tn_q;
		j.dest = in_data.dest_uid;
		j.src = src_q;
		j.cc = in_data.command_class;
		j.pid = in_data.param_id;
		j.pdl = pdl;
		j.b = b;
		j.to_uid = pend_uid_q;
		j.to_pid = pend_pid_q;
		unique case (cmd_t'(in_data.command))
			CMD_START: begin
				j.timeout = pend_q;
				j.header = 1'b1;
				j.sum = (pdl == 8'd0);
			end
			CMD_PARAM: begin
				j.tx_one = (params_left_q != 8'd0);
				j.sum = (params_left_q == 8'd1);
			end
			CMD_TICK: begin
				j.timeout = pend_q && ({2'b0, el_n} >= {2'b0, tmo_q});
			end
			CMD_RX: begin
				if (p != 8'd255 && !(rx_rej_q && !first)) begin
					if (p == 8'd22 && pend_q && pend_tn_q == rx_tn_q) begin
						if (rx_type_q == RespAck) begin
							j.report = 1'b1;
							j.rep.kind = KIND_ACK;
							j.rep.device_uid = rx_uid_q;
							j.rep.report_pid = rx_pid_q;
							j.rep.data_count = cnt;
						end else if (rx_type_q == RespNack && b < 8'd2) begin
							j.report = 1'b1;
							j.rep.kind = KIND_NACK;
							j.rep.device_uid = rx_uid_q;
							j.rep.report_pid = rx_pid_q;
						end
					end else if (p >= 8'd23) begin
						if (rx_type_q == RespAck) begin
							if (dn < rx_len_q) begin
								j.report = 1'b1;
								j.rep.kind = KIND_ACKDATA;
								j.rep.out_byte = b;
							end
						end else if (p != 8'd23) begin
							j.report = 1'b1;
							j.rep.kind = KIND_NACK;
							j.rep.device_uid = rx_uid_q;
							j.rep.report_pid = rx_pid_q;
							j.rep.nack_reason = {rx_rh_q, b};
							j.rep.has_reason = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// a job is only queued when it yields words
	assign job_valid = in_valid && (j.timeout || j.header || j.tx_one || j.report);
	assign job = j;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= SourceUidReset;
			tmo_q <= TimeoutReset;
			next_tn_q <= '0; pend_tn_q <= '0; params_left_q <= '0;
			pend_q <= 1'b0; pend_uid_q <= '0; pend_pid_q <= '0; elapsed_q <= '0;
			rx_idx_q <= '0; rx_tn_q <= '0; rx_type_q <= '0; rx_len_q <= '0;
			rx_rh_q <= '0; rx_rej_q <= 1'b0; rx_uid_q <= '0; rx_pid_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_SOURCE_UID) src_q <= cfg_data[47:0];
				else if (cfg_index == REG_TIMEOUT) tmo_q <= cfg_data[13:0];
			end
			if (acc) begin
				unique case (cmd_t'(in_data.command))
					CMD_START: begin
						next_tn_q <= next_tn_q + 8'd1;
						pend_q <= 1'b1;
						pend_tn_q <= next_tn_q;
						pend_uid_q <= in_data.dest_uid;
						pend_pid_q <= in_data.param_id;
						elapsed_q <= '0;
						params_left_q <= pdl;
					end
					CMD_PARAM: begin
						if (params_left_q != 8'd0) params_left_q <= params_left_q - 8'd1;
					end
					CMD_TICK: begin
						if (pend_q) begin
							elapsed_q <= el_n;
							if (j.timeout) pend_q <= 1'b0;
						end
					end
					CMD_RX: begin
						if (first) rx_rej_q <= 1'b0;
						if (p != 8'd255) begin
							rx_idx_q <= p + 8'd1;
							if (!(rx_rej_q && !first)) begin
								if (p == 8'd0) begin
									if (b != StartCode) rx_rej_q <= 1'b1;
								end else if (p == 8'd1) begin
									if (b < MinLength) rx_rej_q <= 1'b1;
								end else if (p >= 8'd8 && p <= 8'd13) begin
									rx_uid_q <= {rx_uid_q[39:0], b};
								end else if (p == 8'd14) rx_tn_q <= b;
								else if (p == 8'd15) rx_type_q <= b;
								else if (p == 8'd19) begin
									if (b != GetResponse && b != SetResponse) rx_rej_q <= 1'b1;
								end else if (p == 8'd20) rx_pid_q <= {b, 8'd0};
								else if (p == 8'd21) rx_pid_q <= {rx_pid_q[15:8], b};
								else if (p == 8'd22) begin
									rx_rej_q <= 1'b1;
									if (pend_q && pend_tn_q == rx_tn_q) begin
										pend_q <= 1'b0;
										rx_len_q <= cnt;
										if (rx_type_q == RespAck && cnt != 8'd0) rx_rej_q <= 1'b0;
										if (rx_type_q == RespNack && b >= 8'd2) rx_rej_q <= 1'b0;
									end
								end else if (p >= 8'd23) begin
									if (rx_type_q == RespAck) begin
										if (p - 8'd22 >= rx_len_q) rx_rej_q <= 1'b1;
									end else if (p == 8'd23) rx_rh_q <= b;
									else rx_rej_q <= 1'b1;
								end
							end
						end
					end
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

[rtl/rdm_queue.sv]
`default_nettype none
module rdm_queue #(
	parameter int Depth = rdm_pkg::QueueDepth
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	input  wire rdm_pkg::job_t wr_data,
	output logic               rd_valid,
	input  wire logic          rd_ready,
	output rdm_pkg::job_t      rd_data
);
	import rdm_pkg::*;
	localparam int AW = $clog2(Depth);

	job_t          mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          wr, rd;

	assign wr_ready = (cnt_q != Depth[AW:0]);
	assign rd_valid = (cnt_q != '0);
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

[rtl/rdm_back.sv]
`default_nettype none
module rdm_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output logic               job_ready,
	input  wire rdm_pkg::job_t job,
	output logic               out_valid,
	input  wire logic          out_ready,
	output rdm_pkg::out_word_t out_data
);
	import rdm_pkg::*;

	// step: 0 timeout, 1..23 header bytes, 25 one tx byte, 26 sum hi, 27 sum lo, 28 report
	logic [4:0]  step_q;
	logic        busy_q;
	logic [15:0] sum_q;
	logic        ov_q;
	out_word_t   od_q;

	logic [4:0]  first_step, nstep;
	logic        done;
	logic [7:0]  hb;
	logic        last_w;
	out_word_t   w;
	logic        adv;
	logic [15:0] sum_n;

	always_comb begin
		if (job.timeout) first_step = 5'd0;
		else if (job.header) first_step = 5'd1;
		else if (job.tx_one) first_step = 5'd25;
		else first_step = 5'd28;
	end

	always_comb begin
		unique case (step_q)
			5'd1: hb = StartCode;
			5'd2: hb = MinLength + job.pdl;
			5'd3: hb = job.dest[47:40];
			5'd4: hb = job.dest[39:32];
			5'd5: hb = job.dest[31:24];
			5'd6: hb = job.dest[23:16];
			5'd7: hb = job.dest[15:8];
			5'd8: hb = job.dest[7:0];
			5'd9: hb = job.src[47:40];
			5'd10: hb = job.src[39:32];
			5'd11: hb = job.src[31:24];
			5'd12: hb = job.src[23:16];
			5'd13: hb = job.src[15:8];
			5'd14: hb = job.src[7:0];
			5'd15: hb = job.tn;
			5'd16: hb = 8'h01;
			5'd20: hb = job.cc;
			5'd21: hb = job.pid[15:8];
			5'd22: hb = job.pid[7:0];
			5'd23: hb = job.pdl;
			5'd25: hb = job.b;
			5'd26: hb = sum_q[15:8];
			5'd27: hb = sum_q[7:0];
			default: hb = 8'h00;
		endcase
	end

	always_comb begin
		nstep = step_q + 5'd1;
		done = 1'b0;
		unique case (step_q)
			5'd0: begin
				if (job.header) nstep = 5'd1;
				else done = 1'b1;
			end
			5'd23: begin
				if (job.sum) nstep = 5'd26;
				else done = 1'b1;
			end
			5'd25: begin
				if (job.sum) nstep = 5'd26;
				else done = 1'b1;
			end
			5'd27, 5'd28, 5'd24, 5'd29, 5'd30, 5'd31: done = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		w = '0;
		if (step_q == 5'd0) begin
			w.kind = KIND_TIMEOUT;
			w.device_uid = job.to_uid;
			w.report_pid = job.to_pid;
		end else if (step_q == 5'd28) begin
			w = job.rep;
		end else begin
			w.kind = KIND_TX;
			w.out_byte = hb;
		end
		w.last = done;
	end

	// header seeds sum at 0xCC; header and parameter bytes add
	always_comb begin
		if (step_q == 5'd1) sum_n = {8'd0, SumSeed} + {8'd0, hb};
		else if (step_q <= 5'd25) sum_n = sum_q + {8'd0, hb};
		else sum_n = sum_q;
	end

	assign adv = busy_q && (!ov_q || out_ready);
	assign job_ready = adv && done;
	assign out_valid = ov_q;
	assign out_data = od_q;

	always_ff @(posedge clk) begin
		if (adv) od_q <= w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0; busy_q <= 1'b0; sum_q <= '0; ov_q <= 1'b0;
		end else begin
			if (adv) begin
				ov_q <= 1'b1;
				sum_q <= sum_n;
			end else if (out_ready) ov_q <= 1'b0;
			if (!busy_q || (adv && done)) begin
				busy_q <= job_valid && !(adv && done);
				step_q <= first_step;
				if (adv && done) busy_q <= 1'b0;
			end else if (adv) step_q <= nstep;
		end
	end
endmodule
`default_nettype wire

[rtl/rdm_controller_transaction.sv]
`default_nettype none
// channel | dir | word
// in_ch   | in  | command, request header fields, data_byte, frame_first
// out_ch  | out | kind, out_byte, device_uid, report_pid, data_count, nack_reason, has_reason, last
// cfg     | in  | cfg_we, cfg_index, cfg_data
// the front part takes one input word a cycle while the job queue has room and
// updates all transaction and receive state at once
// the back part loads a job, then emits one output word a cycle unless the output stalls:
// a start: any timeout, the header, any sum; a parameter byte: the byte, any sum; rx: a report
// arst_n clears all control state; registers come up at their reset values
// a stalled output holds the back part, which fills the queue and then holds the input
module rdm_controller_transaction #(
	parameter int Depth = rdm_pkg::QueueDepth
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [rdm_pkg::CfgAddrW-1:0] cfg_index,
	input  wire logic [rdm_pkg::CfgDataW-1:0] cfg_data,
	rdm_stream_if.sink   in_ch,
	rdm_stream_if.source out_ch
);
	import rdm_pkg::*;

	logic  fj_valid, bj_valid, bj_ready;
	job_t  fj, bj;
	logic  q_ready;

	rdm_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.job_valid(fj_valid), .job_ready(q_ready), .job(fj)
	);

	rdm_queue #(.Depth(Depth)) u_queue (
		.clk, .arst_n,
		.wr_valid(fj_valid), .wr_ready(q_ready), .wr_data(fj),
		.rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
	);

	rdm_back u_back (
		.clk, .arst_n,
		.job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
	);
endmodule
`default_nettype wire

[dv/tb.sv]
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rdm_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgAddrW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	rdm_stream_if #(.T(in_word_t)) in_ch ();
	rdm_stream_if #(.T(out_word_t)) out_ch ();

	rdm_controller_transaction dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #5 clk = ~clk;

	// shadow of the controller: registers and transaction/receive state
	logic [47:0] own_uid;
	logic [13:0] timeout_limit;
	logic [7:0]  next_tn, pend_tn, tx_left, rx_pos, rx_tn, rx_type, rx_len, rx_hi;
	logic        pend, rx_drop;
	logic [47:0] pend_uid, rx_uid;
	logic [15:0] pend_pid, rx_pid, frame_sum;
	logic [13:0] elapsed;

	out_word_t expected_words[$];
	int errors = 0;
	int cycles = 0;
	bit flushing = 1'b0;

	task automatic report_mismatch(string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	function automatic void emit(kind_t k, logic [7:0] b, logic [47:0] uid,
		logic [15:0] pid, logic [7:0] cnt, logic [15:0] reason, logic hasr);
		out_word_t w;
		w.kind = k;
		w.out_byte = b;
		w.device_uid = uid;
		w.report_pid = pid;
		w.data_count = cnt;
		w.nack_reason = reason;
		w.has_reason = hasr;
		w.last = 1'b0;
		expected_words = {expected_words, w};
	endfunction

	// transmit byte, folded into the running frame sum
	function automatic void send_byte(logic [7:0] b);
		frame_sum = frame_sum + 16'(b);
		emit(KIND_TX, b, '0, '0, '0, '0, 1'b0);
	endfunction

	function automatic void send_sum();
		emit(KIND_TX, frame_sum[15:8], '0, '0, '0, '0, 1'b0);
		emit(KIND_TX, frame_sum[7:0], '0, '0, '0, '0, 1'b0);
	endfunction

	function automatic void decode_rx(logic [7:0] b, logic first);
		int p;
		logic [7:0] cnt;
		if (first) begin
			rx_pos = '0;
			rx_drop = 1'b0;
		end
		p = int'(rx_pos);
		if (p == 255) return;
		rx_pos = rx_pos + 8'd1;
		if (rx_drop) return;
		if (p == 0) begin
			if (b != StartCode) rx_drop = 1'b1;
		end else if (p == 1) begin
			if (b < MinLength) rx_drop = 1'b1;
		end else if (p >= 8 && p <= 13) begin
			rx_uid = {rx_uid[39:0], b};
		end else if (p == 14) begin
			rx_tn = b;
		end else if (p == 15) begin
			rx_type = b;
		end else if (p == 19) begin
			if (b != GetResponse && b != SetResponse) rx_drop = 1'b1;
		end else if (p == 20) begin
			rx_pid = {b, 8'h00};
		end else if (p == 21) begin
			rx_pid[7:0] = b;
		end else if (p == 22) begin
			// decision point: match against the pending transaction
			cnt = (b > MaxParams) ? MaxParams : b;
			rx_drop = 1'b1;
			if (!pend || pend_tn != rx_tn) return;
			pend = 1'b0;
			rx_len = cnt;
			if (rx_type == RespAck) begin
				emit(KIND_ACK, '0, rx_uid, rx_pid, cnt, '0, 1'b0);
				if (cnt > 0) rx_drop = 1'b0;
			end else if (rx_type == RespNack) begin
				if (b < 2) emit(KIND_NACK, '0, rx_uid, rx_pid, '0, '0, 1'b0);
				else rx_drop = 1'b0;
			end
		end else if (p >= 23) begin
			if (rx_type == RespAck) begin
				if (p - 23 < rx_len) emit(KIND_ACKDATA, b, '0, '0, '0, '0, 1'b0);
				if (p - 22 >= rx_len) rx_drop = 1'b1;
			end else if (p == 23) begin
				rx_hi = b;
			end else begin
				emit(KIND_NACK, '0, rx_uid, rx_pid, '0, {rx_hi, b}, 1'b1);
				rx_drop = 1'b1;
			end
		end
	endfunction

	// works out the output words caused by one accepted input word
	function automatic void predict_words(in_word_t w);
		int queued;
		logic [7:0] pdl;
		queued = expected_words.size();
		case (cmd_t'(w.command))
			CMD_START: begin
				pdl = (w.param_length > MaxParams) ? MaxParams : w.param_length;
				if (pend) emit(KIND_TIMEOUT, '0, pend_uid, pend_pid, '0, '0, 1'b0);
				pend = 1'b1;
				pend_tn = next_tn;
				pend_uid = w.dest_uid;
				pend_pid = w.param_id;
				elapsed = '0;
				frame_sum = 16'(SumSeed);
				send_byte(StartCode);
				send_byte(8'd24 + pdl);
				for (int i = 40; i >= 0; i -= 8) send_byte(w.dest_uid[i +: 8]);
				for (int i = 40; i >= 0; i -= 8) send_byte(own_uid[i +: 8]);
				send_byte(next_tn);
				send_byte(8'h01);
				send_byte(8'h00);
				send_byte(8'h00);
				send_byte(8'h00);
				send_byte(w.command_class);
				send_byte(w.param_id[15:8]);
				send_byte(w.param_id[7:0]);
				send_byte(pdl);
				next_tn = next_tn + 8'd1;
				tx_left = pdl;
				if (pdl == 0) send_sum();
			end
			CMD_PARAM: begin
				if (tx_left > 0) begin
					send_byte(w.data_byte);
					tx_left = tx_left - 8'd1;
					if (tx_left == 0) send_sum();
				end
			end
			CMD_RX: decode_rx(w.data_byte, w.frame_first);
			default: begin
				if (pend) begin
					if (elapsed != 14'h3FFF) elapsed = elapsed + 14'd1;
					if (elapsed >= timeout_limit) begin
						emit(KIND_TIMEOUT, '0, pend_uid, pend_pid, '0, '0, 1'b0);
						pend = 1'b0;
					end
				end
			end
		endcase
		if (expected_words.size() > queued) expected_words[$].last = 1'b1;
	endfunction

	// random gap: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// drive one word and hold it until accepted; valid drops between words only for a random gap
	task automatic send_word(in_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		do @(posedge clk); while (!in_ch.ready);
		predict_words(w);
	endtask

	function automatic in_word_t random_word();
		in_word_t w;
		w.command = 2'($urandom_range(0, 3));
		w.dest_uid = {16'($urandom), 32'($urandom)};
		w.command_class = 8'($urandom);
		w.param_id = 16'($urandom);
		w.param_length = 8'($urandom_range(0, 5));
		w.data_byte = 8'($urandom);
		w.frame_first = 1'($urandom);
		return w;
	endfunction

	function automatic in_word_t cmd_word(cmd_t c, logic [7:0] b, logic first);
		in_word_t w;
		w = random_word();
		w.command = c;
		w.data_byte = b;
		w.frame_first = first;
		return w;
	endfunction

	task automatic start_request(logic [7:0] pdl);
		in_word_t w;
		w = random_word();
		w.command = CMD_START;
		w.command_class = ($urandom_range(0, 1)) ? 8'h20 : 8'h30;
		w.param_length = pdl;
		send_word(w);
		for (int i = 0; i < pdl; i++) send_word(cmd_word(CMD_PARAM, 8'($urandom), 1'b0));
	endtask

	// one received response frame; stop_at cuts it short, bad_at spoils one byte
	// the message length byte caps at 255 for long parameter data
	task automatic receive_frame(logic [7:0] tn, logic [7:0] rtype, logic [7:0] cls,
		logic [7:0] pdl, int stop_at, int bad_at);
		logic [7:0] frame[$];
		logic [7:0] b;
		frame = {StartCode, (pdl > MaxParams) ? 8'hFF : 8'd24 + pdl};
		for (int i = 2; i < 14; i++) frame = {frame, 8'($urandom)};
		frame = {frame, tn};
		frame = {frame, rtype};
		frame = {frame, 8'($urandom)};
		frame = {frame, 8'($urandom)};
		frame = {frame, 8'($urandom)};
		frame = {frame, cls};
		frame = {frame, 8'($urandom)};
		frame = {frame, 8'($urandom)};
		frame = {frame, pdl};
		for (int i = 0; i < pdl; i++) frame = {frame, 8'($urandom)};
		for (int i = 0; i < frame.size() && i < stop_at; i++) begin
			b = (i == bad_at) ? 8'($urandom) : frame[i];
			send_word(cmd_word(CMD_RX, b, i == 0));
		end
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		wait (expected_words.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [47:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SOURCE_UID) own_uid = value;
		else timeout_limit = value[13:0];
	endtask

	// one random transaction: mostly well formed, some noise and broken frames
	task automatic random_transaction(int ticks);
		int r;
		logic [7:0] tn;
		logic [7:0] rtype;
		start_request(8'($urandom_range(0, 4)));
		tn = next_tn - 8'd1;
		r = $urandom_range(0, 9);
		rtype = (r < 5) ? RespAck : (r < 8) ? RespNack : 8'($urandom);
		r = $urandom_range(0, 9);
		if (r < 6) begin
			receive_frame(tn, rtype, ($urandom_range(0, 1)) ? GetResponse : SetResponse,
				8'($urandom_range(0, 4)), 1000, -1);
		end else if (r == 6) begin
			receive_frame(tn + 8'($urandom_range(1, 255)), rtype, GetResponse, 2, 1000, -1);
		end else if (r == 7) begin
			receive_frame(tn, rtype, SetResponse, 3, $urandom_range(1, 25), -1);
		end else if (r == 8) begin
			receive_frame(tn, rtype, GetResponse, 2, 1000, $urandom_range(0, 24));
		end else begin
			repeat ($urandom_range(1, 4)) send_word(random_word());
		end
		for (int i = 0; i < ticks; i++) send_word(cmd_word(CMD_TICK, 8'($urandom), 1'b0));
	endtask

	typedef struct {
		in_word_t  word;
		bit        pinned;
		out_word_t first_out;
	} stim_row_t;

	function automatic stim_row_t row(cmd_t c, logic [47:0] dest, logic [15:0] pid,
		logic [7:0] pdl, logic [7:0] b, logic first);
		stim_row_t s;
		s.word = '{command: c, dest_uid: dest, command_class: 8'h20, param_id: pid,
			param_length: pdl, data_byte: b, frame_first: first};
		s.pinned = 1'b0;
		s.first_out = '0;
		return s;
	endfunction

	function automatic stim_row_t pin(stim_row_t s, kind_t k, logic [7:0] b,
		logic [47:0] uid, logic [15:0] pid);
		s.pinned = 1'b1;
		s.first_out = '{kind: k, out_byte: b, device_uid: uid, report_pid: pid,
			data_count: 8'd0, nack_reason: 16'd0, has_reason: 1'b0, last: 1'b0};
		return s;
	endfunction

	// output side: random stalls, compare every accepted word with the oldest expectation
	int stall_left = 0;
	always @(posedge clk) begin
		out_word_t got, want;
		if (arst_n) cycles++;
		if (out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word kind %0d", got.kind));
			end else begin
				want = expected_words.pop_front();
				if (got.kind != want.kind)
					report_mismatch($sformatf("kind %0d want %0d", got.kind, want.kind));
				if (got.out_byte != want.out_byte)
					report_mismatch($sformatf("out_byte %h want %h", got.out_byte, want.out_byte));
				if (got.device_uid != want.device_uid)
					report_mismatch($sformatf("device_uid %h want %h",
						got.device_uid, want.device_uid));
				if (got.report_pid != want.report_pid)
					report_mismatch($sformatf("report_pid %h want %h",
						got.report_pid, want.report_pid));
				if (got.data_count != want.data_count)
					report_mismatch($sformatf("data_count %0d want %0d",
						got.data_count, want.data_count));
				if (got.nack_reason != want.nack_reason)
					report_mismatch($sformatf("nack_reason %h want %h",
						got.nack_reason, want.nack_reason));
				if (got.has_reason != want.has_reason)
					report_mismatch($sformatf("has_reason %b want %b",
						got.has_reason, want.has_reason));
				if (got.last != want.last)
					report_mismatch($sformatf("last %b want %b", got.last, want.last));
			end
		end
		// stall runs: mostly short, a few long, plenty of stretches with none
		if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (!flushing && $urandom_range(0, 9) < 2) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 3);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
		if (cycles > 400000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		stim_row_t directed[$];
		int queued;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		own_uid = SourceUidReset;
		timeout_limit = TimeoutReset;
		{next_tn, pend_tn, tx_left, rx_pos, rx_tn, rx_type, rx_len, rx_hi} = '0;
		{pend, rx_drop, pend_uid, rx_uid, pend_pid, rx_pid, frame_sum, elapsed} = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: reset values, field extremes, every command
		directed = {
			row(CMD_TICK, '0, '0, 0, 8'h00, 1'b0),                 // tick with nothing pending
			row(CMD_PARAM, '0, '0, 0, 8'hFF, 1'b0),                // parameter with none owed
			pin(row(CMD_START, '1, '1, 0, 8'h00, 1'b0), KIND_TX, StartCode, '0, '0),
			pin(row(CMD_START, '0, '0, 2, 8'h00, 1'b0), KIND_TIMEOUT, 8'h00, '1, '1),
			row(CMD_PARAM, '0, '0, 0, 8'hFF, 1'b0),
			row(CMD_PARAM, '0, '0, 0, 8'h00, 1'b0),
			row(CMD_PARAM, '0, '0, 0, 8'hA5, 1'b0),                // extra byte ignored
			row(CMD_START, 48'h123456789ABC, 16'h8001, 8'hFF, 8'h00, 1'b0), // saturated length
			row(CMD_PARAM, '0, '0, 0, 8'h5A, 1'b0),
			row(CMD_START, 48'h800000000001, 16'h0001, 1, 8'h00, 1'b0), // abandons last frame
			row(CMD_PARAM, '0, '0, 0, 8'h80, 1'b0),
			row(CMD_RX, '0, '0, 0, 8'h01, 1'b0),                   // no frame start after reset
			row(CMD_RX, '0, '0, 0, 8'h02, 1'b1),                   // bad start code
			row(CMD_RX, '0, '0, 0, 8'h01, 1'b1),
			row(CMD_RX, '0, '0, 0, 8'd23, 1'b0),                   // length below minimum
			row(CMD_RX, '0, '0, 0, 8'hFF, 1'b0),
			row(CMD_TICK, '0, '0, 0, 8'hFF, 1'b1)
		};
		foreach (directed[i]) begin
			queued = expected_words.size();
			send_word(directed[i].word);
			if (directed[i].pinned) begin
				if (expected_words.size() <= queued)
					report_mismatch($sformatf("row %0d gives no word", i));
				else if (expected_words[queued] != directed[i].first_out)
					report_mismatch($sformatf("row %0d first word disagrees", i));
			end
		end

		// long ack cut short: data count saturates, a few data bytes follow
		start_request(0);
		receive_frame(next_tn - 8'd1, RespAck, GetResponse, 8'hF0, 26, -1);
		// nack carrying a reason code
		start_request(0);
		receive_frame(next_tn - 8'd1, RespNack, SetResponse, 2, 1000, -1);

		// short timeout so a few ticks expire the request, all-zero source id
		wait_idle();
		write_reg(REG_SOURCE_UID, '0);
		write_reg(REG_TIMEOUT, 48'd4);
		start_request(0);
		repeat (5) send_word(cmd_word(CMD_TICK, 8'($urandom), 1'b0));
		random_transaction($urandom_range(0, 6));

		// long timeout, all-ones source id
		wait_idle();
		write_reg(REG_SOURCE_UID, '1);
		write_reg(REG_TIMEOUT, 48'd10000);
		random_transaction($urandom_range(0, 4));

		// back to the default timeout with a random id
		wait_idle();
		write_reg(REG_SOURCE_UID, {16'($urandom), 32'($urandom)});
		write_reg(REG_TIMEOUT, 48'(TimeoutReset));
		random_transaction($urandom_range(0, 4));

		in_ch.valid <= 1'b0;
		flushing = 1'b1;
		wait (expected_words.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

[rdm_controller_transaction.f]
rtl/rdm_pkg.sv
rtl/rdm_stream_if.sv
rtl/rdm_front.sv
rtl/rdm_queue.sv
rtl/rdm_back.sv
rtl/rdm_controller_transaction.sv
dv/tb.sv
